// ===== rtl/kpe_pkg.sv =====
// Package for the k-permutation enumerator: widths, reset values, status and
// register codes, sequencer states and the structs passed between modules.
// No dependencies.
package kpe_pkg;

	localparam int MAX_LENGTH_DEF  = 8;
	localparam int MAX_SYMBOLS_DEF = 16;

	localparam int N_W         = 5;
	localparam int K_W         = 4;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 5;
	localparam int IN_DATA_W   = 8;
	localparam int ARR_W       = 32;
	localparam int NIB_W       = 4;

	localparam logic [N_W-1:0] SYMBOL_COUNT_RST     = 5'd4;
	localparam logic [K_W-1:0] SELECTION_LENGTH_RST = 4'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SELECTION_LENGTH = 4'd1;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_EXHAUSTED  = 2'd1,
		STATUS_BAD_CONFIG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TRY,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [N_W-1:0] symbol_count;
		logic [K_W-1:0] selection_length;
	} cfg_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} done_t;

endpackage

// ===== rtl/kpe_cfg_regs.sv =====
// Configuration registers of the enumerator: symbol count and selection length.
// Depends on kpe_pkg.
module kpe_cfg_regs
	import kpe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg,
	output logic                   cfg_wr
);

	cfg_t cfg_q;
	logic xfer;

	assign cfg_ready = 1'b1;
	assign xfer      = cfg_valid && cfg_ready;
	assign cfg_wr    = xfer && ((cfg_index == CFG_SYMBOL_COUNT) ||
		(cfg_index == CFG_SELECTION_LENGTH));
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.symbol_count     <= SYMBOL_COUNT_RST;
			cfg_q.selection_length <= SELECTION_LENGTH_RST;
		end else if (xfer) begin
			unique case (cfg_index)
				CFG_SYMBOL_COUNT: begin
					cfg_q.symbol_count <= cfg_data[N_W-1:0];
				end
				CFG_SELECTION_LENGTH: begin
					cfg_q.selection_length <= cfg_data[K_W-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/kpe_odometer.sv =====
// Sequencer and digit store: finds the next distinct tuple by testing one
// candidate symbol a cycle against a used-symbol mask. Depends on kpe_pkg.
module kpe_odometer
	import kpe_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	localparam int DW = $clog2(MAX_SYMBOLS)
)
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           cfg_wr,
	input  logic                           start,
	input  logic                           restart,
	output logic                           idle,
	output done_t                          done,
	output logic [MAX_LENGTH-1:0][DW-1:0]  digits
);

	localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int VW = $clog2(MAX_SYMBOLS + 1);
	localparam int NS = 1 << DW;
	localparam int CW = (VW > N_W) ? VW : N_W;

	state_t                        state_q, state_d;
	logic [PW-1:0]                 pos_q;
	logic [VW-1:0]                 v_q;
	logic [NS-1:0]                 used_q;
	logic [MAX_LENGTH-1:0][DW-1:0] digits_q;
	logic                          started_q, exhausted_q;
	status_t                       status_q;

	logic          cfg_ok, at_last, at_first, v_ge_n, v_used;
	logic [DW-1:0] v_idx, cur_digit;

	assign cfg_ok = (cfg.selection_length != '0) &&
		(int'(cfg.selection_length) <= MAX_LENGTH) &&
		(cfg.selection_length <= cfg.symbol_count) &&
		(int'(cfg.symbol_count) <= MAX_SYMBOLS);
	assign at_last   = (K_W'(pos_q) == (cfg.selection_length - K_W'(1)));
	assign at_first  = (pos_q == '0);
	assign v_ge_n    = (CW'(v_q) >= CW'(cfg.symbol_count));
	assign v_idx     = v_q[DW-1:0];
	assign v_used    = used_q[v_idx];
	assign cur_digit = digits_q[pos_q];
	assign digits    = digits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idle        = 1'b0;
		done.valid  = 1'b0;
		done.status = status_q;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (!cfg_ok) begin
						state_d = ST_DONE;
					end else if (restart || !started_q) begin
						state_d = ST_FILL;
					end else if (exhausted_q) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				state_d = ST_TRY;
			end
			ST_TRY: begin
				if (v_ge_n) begin
					state_d = at_first ? ST_DONE : ST_LOAD;
				end else if (!v_used) begin
					state_d = at_last ? ST_DONE : ST_FILL;
				end
			end
			ST_FILL: begin
				if (!v_used && at_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done.valid = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			exhausted_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (!cfg_ok) begin
							started_q   <= 1'b0;
							exhausted_q <= 1'b0;
						end else if (restart || !started_q) begin
							started_q   <= 1'b1;
							exhausted_q <= 1'b0;
						end
					end
				end
				ST_TRY: begin
					if (v_ge_n && at_first) begin
						exhausted_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (cfg_wr) begin
				started_q   <= 1'b0;
				exhausted_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!cfg_ok) begin
						status_q <= STATUS_BAD_CONFIG;
					end else if (restart || !started_q) begin
						status_q <= STATUS_OK;
						pos_q    <= '0;
						v_q      <= '0;
						used_q   <= '0;
					end else if (exhausted_q) begin
						status_q <= STATUS_EXHAUSTED;
					end else begin
						status_q <= STATUS_OK;
						pos_q    <= PW'(cfg.selection_length - K_W'(1));
					end
				end
			end
			ST_LOAD: begin
				used_q[cur_digit] <= 1'b0;
				v_q               <= VW'(cur_digit) + VW'(1);
			end
			ST_TRY: begin
				if (v_ge_n) begin
					if (at_first) begin
						status_q <= STATUS_EXHAUSTED;
					end else begin
						pos_q <= pos_q - PW'(1);
					end
				end else if (!v_used) begin
					digits_q[pos_q] <= v_idx;
					used_q[v_idx]   <= 1'b1;
					if (!at_last) begin
						pos_q <= pos_q + PW'(1);
						v_q   <= '0;
					end
				end else begin
					v_q <= v_q + VW'(1);
				end
			end
			ST_FILL: begin
				v_q <= v_q + VW'(1);
				if (!v_used) begin
					digits_q[pos_q] <= v_idx;
					used_q[v_idx]   <= 1'b1;
					if (!at_last) begin
						pos_q <= pos_q + PW'(1);
					end
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("start outside idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q != ST_IDLE)
		else $error("sequencer did not leave idle");

	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done.valid && done.status == STATUS_OK) |->
			$countones(used_q) == int'(cfg.selection_length))
		else $error("used mask does not hold k symbols");
`endif

endmodule

// ===== rtl/k_permutation_enumerator_core.sv =====
// Top level of the k-permutation enumerator: configuration port, sequencer and
// registered result stage. Depends on kpe_pkg, kpe_cfg_regs and kpe_odometer.
//
// Each request gives the next ordered selection of k distinct symbols out of n
// in lexicographic order, or the first one on restart or when none has been
// given since reset or a configuration write. One item at a time: the
// sequencer tests one candidate symbol per cycle against a mask of the symbols
// in use. A restart fills the digits from the left. An advance reloads each
// digit visited from the right and tests candidate symbols there, then steps
// through the symbols while refilling the tail. Bad configuration and
// exhausted answers skip the search. The result sits in an output register,
// and the next request is taken once the sequencer is idle and that register
// is free or being drained.
module k_permutation_enumerator_core
	import kpe_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // [0] restart
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [ARR_W-1:0]       m_tdata,   // [31:0] arrangement
	output logic                   m_tlast,   // final_one
	output logic [1:0]             m_tuser,   // [1:0] status
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DW = $clog2(MAX_SYMBOLS);

	cfg_t                          cfg;
	logic                          cfg_wr;
	logic                          odo_idle, start;
	done_t                         done;
	logic [MAX_LENGTH-1:0][DW-1:0] digits;
	logic [ARR_W-1:0]              packed_arr;
	logic                          last;

	logic             m_tvalid_q, m_tlast_q;
	logic [ARR_W-1:0] m_tdata_q;
	status_t          m_tuser_q;

	kpe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cfg_wr    (cfg_wr)
	);

	kpe_odometer #(
		.MAX_LENGTH  (MAX_LENGTH),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_odo (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr),
		.start   (start),
		.restart (s_tdata[0]),
		.idle    (odo_idle),
		.done    (done),
		.digits  (digits)
	);

	assign s_tready = odo_idle && (!m_tvalid_q || m_tready);
	assign start    = s_tvalid && s_tready;

	// digit 0 ends up in the top used nibble
	always_comb begin
		packed_arr = '0;
		last       = 1'b1;
		for (int i = 0; i < MAX_LENGTH; i++) begin
			if (i < int'(cfg.selection_length)) begin
				packed_arr = {packed_arr[ARR_W-NIB_W-1:0], NIB_W'(digits[i])};
				if (int'(digits[i]) != int'(cfg.symbol_count) - 1 - i) begin
					last = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			m_tdata_q <= (done.status == STATUS_OK) ? packed_arr : '0;
			m_tlast_q <= (done.status == STATUS_OK) && last;
			m_tuser_q <= done.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef NO_ASSERTIONS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> !m_tvalid_q)
		else $error("result overwrote an untaken transfer");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> m_tuser_q == STATUS_OK)
		else $error("final flag on a non-arrangement result");

	a_blank_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q != STATUS_OK) |-> m_tdata_q == '0)
		else $error("arrangement not cleared on error status");
`endif

endmodule
